FILE: rtl/button_debounce_long_press_assert.svh
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Shared concurrent assertion forms for the debounce block.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// implication, skipped while reset is asserted
`define BDLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, evaluated during reset as well
`define BDLP_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants shared by the button debounce / long press block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_LONG    = 2'd2;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] stamp_ms;
        logic [31:0] hold_ms;
        logic [31:0] press_count;
        logic [31:0] last_press_stamp;
        logic        final_flag;
    } t_result;

    // results produced by one sample, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

FILE: rtl/bdlp_in_if.sv
// ----------------------------------------------------------------------------
// bdlp_in_if
// Poll sample channel: valid/ready handshake with sample payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdlp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        pin_level;
    logic        edge_flag;

    modport source (output valid, output now_ms, output pin_level, output edge_flag,
                    input ready);
    modport sink   (input valid, input now_ms, input pin_level, input edge_flag,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/bdlp_out_if.sv
// ----------------------------------------------------------------------------
// bdlp_out_if
// Button event channel: valid/ready handshake with event payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdlp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [31:0] stamp_ms;
    logic [31:0] hold_ms;
    logic [31:0] press_count;
    logic [31:0] last_press_stamp;
    logic        final_flag;

    modport source (output valid, output event_kind, output stamp_ms, output hold_ms,
                    output press_count, output last_press_stamp, output final_flag,
                    input ready);
    modport sink   (input valid, input event_kind, input stamp_ms, input hold_ms,
                    input press_count, input last_press_stamp, input final_flag,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/bdlp_outq.sv
// ----------------------------------------------------------------------------
// bdlp_outq
// Two-entry event queue; takes up to two events per cycle, emits one when ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_outq
    import bdlp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    output logic [1:0]  o_free,
    bdlp_out_if.source  o_out
);

    t_result    r_q0, r_q1, n_q0, n_q1;
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] cnt_p;
    logic       pop;

    assign pop   = (r_cnt != 2'd0) && o_out.ready;
    assign cnt_p = r_cnt - {1'b0, pop};
    assign o_free = 2'd2 - cnt_p;

    always_comb begin
        n_q0  = pop ? r_q1 : r_q0;
        n_q1  = r_q1;
        n_cnt = cnt_p + i_push.cnt;
        if (cnt_p == 2'd0) begin
            if (i_push.cnt != 2'd0) n_q0 = i_push.res0;
            if (i_push.cnt == 2'd2) n_q1 = i_push.res1;
        end else if (cnt_p == 2'd1) begin
            if (i_push.cnt != 2'd0) n_q1 = i_push.res0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_out.valid            = (r_cnt != 2'd0);
    assign o_out.event_kind       = r_q0.event_kind;
    assign o_out.stamp_ms         = r_q0.stamp_ms;
    assign o_out.hold_ms          = r_q0.hold_ms;
    assign o_out.press_count      = r_q0.press_count;
    assign o_out.last_press_stamp = r_q0.last_press_stamp;
    assign o_out.final_flag       = r_q0.final_flag;

endmodule

`default_nettype wire

FILE: rtl/bdlp_core.sv
// ----------------------------------------------------------------------------
// bdlp_core
// Sample register, debounce state and event generation, config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_core
    import bdlp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    bdlp_in_if.sink                   i_in,
    input  wire logic [1:0]           i_free,
    output t_push                     o_push
);

    logic [CFG_W-1:0] r_debounce, r_long;

    logic        r_valid;
    logic [31:0] r_now;
    logic        r_lvl;
    logic        r_edge;

    logic                 r_stable;
    logic [TIME_BITS-1:0] r_last_change;
    logic                 r_held;
    logic [TIME_BITS-1:0] r_hold_start;
    logic [TIME_BITS-1:0] r_last_long;
    logic [31:0]          r_press_total;
    logic [TIME_BITS-1:0] r_press_stamp;

    logic [TIME_BITS-1:0] now_t, dur, dur2, since_long, since_chg, long_t;
    logic [31:0]          now32, dur32, dur2_32, stamp32, total_n;
    logic                 lvl_chg, void_s, take, press, rel, ongoing, rel_long;
    logic                 held_n;
    logic [1:0]           need;
    logic                 fire;
    t_result              ev_first, ev_long;

    assign now_t      = TIME_BITS'(64'(r_now));
    assign long_t     = TIME_BITS'(r_long);
    assign since_chg  = now_t - r_last_change;
    assign dur        = now_t - r_hold_start;
    assign since_long = now_t - r_last_long;

    assign lvl_chg  = (r_lvl != r_stable);
    assign void_s   = (lvl_chg || r_edge) && (since_chg < TIME_BITS'(r_debounce));
    assign take     = !void_s && lvl_chg;
    assign press    = take && !r_lvl && !r_held;
    assign rel      = take && r_lvl && r_held;
    assign rel_long = (dur >= long_t);
    assign held_n   = press | (r_held & ~rel);
    assign dur2     = press ? '0 : dur;
    assign ongoing  = !void_s && held_n && !r_lvl && (dur2 >= long_t) &&
                      (since_long > long_t);
    assign total_n  = r_press_total + {31'd0, press};

    assign now32   = 32'(64'(now_t));
    assign dur32   = 32'(64'(dur));
    assign dur2_32 = 32'(64'(dur2));
    assign stamp32 = press ? now32 : 32'(64'(r_press_stamp));

    assign need = {1'b0, press} + {1'b0, rel} + {1'b0, ongoing};
    assign fire = r_valid && (need <= i_free);

    assign i_in.ready = !r_valid || fire;

    always_comb begin
        ev_long = '{event_kind: EV_LONG, stamp_ms: now32, hold_ms: dur2_32,
                    press_count: total_n, last_press_stamp: stamp32, final_flag: 1'b1};
        if (press) begin
            ev_first = '{event_kind: EV_PRESS, stamp_ms: now32, hold_ms: 32'd0,
                         press_count: total_n, last_press_stamp: stamp32,
                         final_flag: !ongoing};
        end else if (rel) begin
            ev_first = '{event_kind: rel_long ? EV_LONG : EV_RELEASE, stamp_ms: now32,
                         hold_ms: dur32, press_count: total_n,
                         last_press_stamp: stamp32, final_flag: 1'b1};
        end else begin
            ev_first = ev_long;
        end
        o_push.cnt  = fire ? need : 2'd0;
        o_push.res0 = ev_first;
        o_push.res1 = ev_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= DEBOUNCE_RST;
            r_long        <= LONG_RST;
            r_valid       <= 1'b0;
            r_stable      <= 1'b1;
            r_last_change <= '0;
            r_held        <= 1'b0;
            r_hold_start  <= '0;
            r_last_long   <= '0;
            r_press_total <= '0;
            r_press_stamp <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                    CFG_LONG:     r_long     <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                r_valid <= 1'b1;
            end else if (fire) begin
                r_valid <= 1'b0;
            end
            if (fire) begin
                if (take) begin
                    r_stable      <= r_lvl;
                    r_last_change <= now_t;
                end
                r_held <= held_n;
                if (press) begin
                    r_hold_start  <= now_t;
                    r_press_stamp <= now_t;
                end
                r_press_total <= total_n;
                if (ongoing) r_last_long <= now_t;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_now  <= i_in.now_ms;
            r_lvl  <= i_in.pin_level;
            r_edge <= i_in.edge_flag;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Poll-sample button debouncer with press, release and long-press events.
// ----------------------------------------------------------------------------
// One poll sample is taken per clock while input ready is high. A sample is
// registered, evaluated against the debounce state in the following cycle and
// its zero, one or two events are written to a two-entry output queue. While
// the output takes events, samples giving at most one event flow at one per
// cycle; one giving two (press plus ongoing long press) waits until the queue
// has room for both. Input ready falls only when the queue lacks room for the
// pending sample's events. Configuration writes take effect on the next edge.
`default_nettype none
`include "button_debounce_long_press_assert.svh"

module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    bdlp_in_if.sink                   i_in,
    bdlp_out_if.source                o_out
);

    t_push      push;
    logic [1:0] free;

    bdlp_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_free     (free),
        .o_push     (push)
    );

    bdlp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (free),
        .o_out   (o_out)
    );

    `BDLP_ASSERT_IMP(a_push_fits, i_clk, i_rst_n, push.cnt != 2'd0, push.cnt <= free, "queue overflow")
    `BDLP_ASSERT_IMP(a_pair_final, i_clk, i_rst_n, push.cnt == 2'd2, push.res1.final_flag && !push.res0.final_flag, "bad final flag on event pair")
    `BDLP_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_out.valid, "events present after reset")

endmodule

`default_nettype wire
